// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LengthPos  = 56;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

   typedef struct packed {
      logic       finish;
      logic [7:0] data;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUNDS,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef logic [31:0] word_type;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_h(input logic [2:0] idx);
      word_type h;
      unique case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

// ===== sv/sha_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA request queue
// Small FIFO between the request front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  sha_pkg::entry_type wr_entry,
   output logic               rd_valid,
   input  logic               rd_ready,
   output sha_pkg::entry_type rd_entry
);
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   sha_pkg::entry_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_entry = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_entry;
      end
   end
endmodule

// ===== sv/sha_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA compression engine
// Packs bytes into the block, pads, runs 64 rounds and emits the digest.
// ----------------------------------------------------------------------------
module sha_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sha_pkg::entry_type in_entry,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_word,
   output logic [2:0]         out_index,
   output logic               out_last
);
   sha_pkg::state_type state_ff, state_in;
   sha_pkg::word_type  h_ff [8];
   sha_pkg::word_type  s_ff [8];
   sha_pkg::word_type  w_ff [16];
   logic [5:0]  fill_ff;
   logic [63:0] len_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff;
   logic        second_ff;
   logic [2:0]  idx_ff;

   sha_pkg::word_type t1, t2, wn, wcur, e, a, x, y;
   logic absorb, start_fin;

   assign absorb    = (state_ff == sha_pkg::ST_IDLE) && in_valid && !in_entry.finish;
   assign start_fin = (state_ff == sha_pkg::ST_IDLE) && in_valid && in_entry.finish;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (start_fin) begin
               state_in = sha_pkg::ST_PAD;
            end else if (absorb && fill_ff == 6'(sha_pkg::BlockBytes - 1)) begin
               state_in = sha_pkg::ST_ROUNDS;
            end
         end
         sha_pkg::ST_PAD:    state_in = sha_pkg::ST_ROUNDS;
         sha_pkg::ST_ROUNDS: if (rnd_ff == 6'd63) state_in = sha_pkg::ST_FOLD;
         sha_pkg::ST_FOLD: begin
            if (!fin_ff) state_in = sha_pkg::ST_IDLE;
            else if (second_ff) state_in = sha_pkg::ST_PAD;
            else state_in = sha_pkg::ST_EMIT;
         end
         sha_pkg::ST_EMIT: if (out_ready && idx_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = (state_ff == sha_pkg::ST_IDLE);
      out_valid = (state_ff == sha_pkg::ST_EMIT);
      out_word  = h_ff[idx_ff];
      out_index = idx_ff;
      out_last  = (idx_ff == 3'd7);
   end

   always_comb begin
      wcur = w_ff[0];
      x  = w_ff[1];
      y  = w_ff[14];
      wn = w_ff[0]
         + (sha_pkg::rotr(x, 7) ^ sha_pkg::rotr(x, 18) ^ (x >> 3))
         + w_ff[9]
         + (sha_pkg::rotr(y, 17) ^ sha_pkg::rotr(y, 19) ^ (y >> 10));
      e  = s_ff[4];
      a  = s_ff[0];
      t1 = s_ff[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & s_ff[5]) ^ (~e & s_ff[6])) + sha_pkg::round_k(rnd_ff) + wcur;
      t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & s_ff[1]) ^ (a & s_ff[2]) ^ (s_ff[1] & s_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         fill_ff  <= '0;
         len_ff   <= '0;
         rnd_ff   <= '0;
         fin_ff   <= 1'b0;
         second_ff <= 1'b0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            sha_pkg::ST_IDLE: begin
               if (absorb) begin
                  fill_ff <= fill_ff + 1'b1;
                  len_ff  <= len_ff + 64'd1;
                  rnd_ff  <= '0;
                  fin_ff  <= 1'b0;
               end else if (start_fin) begin
                  fin_ff    <= 1'b1;
                  second_ff <= (fill_ff > 6'(sha_pkg::LengthPos - 1));
               end
               for (int i = 0; i < 8; i++) s_ff[i] <= h_ff[i];
            end
            sha_pkg::ST_PAD: begin
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) s_ff[i] <= h_ff[i];
            end
            sha_pkg::ST_ROUNDS: begin
               rnd_ff <= rnd_ff + 1'b1;
               s_ff[7] <= s_ff[6]; s_ff[6] <= s_ff[5]; s_ff[5] <= s_ff[4];
               s_ff[4] <= s_ff[3] + t1;
               s_ff[3] <= s_ff[2]; s_ff[2] <= s_ff[1]; s_ff[1] <= s_ff[0];
               s_ff[0] <= t1 + t2;
            end
            sha_pkg::ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + s_ff[i];
               idx_ff <= '0;
               if (fin_ff && second_ff) second_ff <= 1'b0;
            end
            sha_pkg::ST_EMIT: begin
               if (out_ready) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
                     fill_ff <= '0;
                     len_ff  <= '0;
                     fin_ff  <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // schedule: 16-word sliding window, bytes and padding in idle, length on PAD
   always_ff @(posedge clock) begin
      priority if (absorb) begin
         w_ff[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] <= in_entry.data;
      end else if (start_fin) begin
         for (int b = 0; b < 64; b++) begin
            if (6'(b) == fill_ff) begin
               w_ff[b/4][8*(3-(b%4)) +: 8] <= sha_pkg::PadByte;
            end else if (6'(b) > fill_ff) begin
               w_ff[b/4][8*(3-(b%4)) +: 8] <= 8'h00;
            end
         end
      end else if (state_ff == sha_pkg::ST_PAD) begin
         // the block holding 0x80 past the length field goes out as it is
         if (!second_ff) begin
            w_ff[14] <= len_ff[60:29];
            w_ff[15] <= {len_ff[28:0], 3'b000};
         end
      end else if (state_ff == sha_pkg::ST_FOLD && fin_ff && second_ff) begin
         // 0x80 landed in the first block; length goes in a block of its own
         for (int i = 0; i < 16; i++) w_ff[i] <= '0;
      end else if (state_ff == sha_pkg::ST_ROUNDS) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wn;
      end
   end
endmodule

// ===== sv/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 with a request queue in front of the compression engine.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one request per byte (req_opcode absorb) or a finish request.
//   rsp_ channel: eight digest words after each finish, rsp_last_word on word 7.
//   A request is registered in the queue before it reaches the engine.
//   Each absorbed byte is written into the block while idle; every 64th byte
//   also runs the rounds and fold through the single round unit.
//   A finish first lays in the padding, then compresses one or two blocks
//   (pad state, 64 rounds, fold; the length goes into the last block),
//   then the eight words at one per accepted cycle.
//   A queue of Depth requests keeps the input side taking bytes while the
//   engine compresses.
//   Reset empties the queue and loads the initial hash values.
//   A stall on rsp_ready holds the current word; the engine waits, the queue
//   keeps filling until full, then req_ready drops.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
   parameter int unsigned Depth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   sha_pkg::entry_type wr_entry, rd_entry;
   logic rd_valid, rd_ready;

   assign wr_entry.finish = (req_opcode == sha_pkg::OP_FINISH);
   assign wr_entry.data   = req_data_byte;

   sha_queue #(.Depth(Depth)) u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(req_valid), .wr_ready(req_ready), .wr_entry(wr_entry),
      .rd_valid(rd_valid), .rd_ready(rd_ready), .rd_entry(rd_entry)
   );

   sha_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(rd_valid), .in_ready(rd_ready), .in_entry(rd_entry),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_word(rsp_digest_word), .out_index(rsp_word_index),
      .out_last(rsp_last_word)
   );
endmodule

// ===== sv/sha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA port checker
// Port-level properties of the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("response changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last flag out of step with index");

   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words not consecutive");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);

// ===== bench/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the request and digest channels, keeps its own hash state, and
// compares every digest word with the value it predicts.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          words_pending
);
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]     chain [8];
   logic [7:0]      block [64];
   int unsigned     fill;
   logic [63:0]     byte_total;
   digest_word_type digest_q [$];

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1, t2, x, y;
      for (int i = 0; i < 16; i++)
         w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         x = w[i-15];
         y = w[i-2];
         w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
              + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
      end
      s = chain;
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundConst[i] + w[i];
         t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
         s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += s[i];
   endtask

   task automatic take_request(input logic op, input logic [7:0] b);
      logic [63:0] bits;
      if (op == sha_pkg::OP_ABSORB) begin
         block[fill] = b;
         fill++;
         byte_total++;
         if (fill == 64) begin
            fold_block();
            fill = 0;
         end
      end else begin
         bits = byte_total << 3;
         block[fill] = sha_pkg::PadByte;
         fill++;
         if (fill > sha_pkg::LengthPos) begin
            for (int i = fill; i < 64; i++) block[i] = 8'h00;
            fold_block();
            fill = 0;
         end
         for (int i = fill; i < sha_pkg::LengthPos; i++) block[i] = 8'h00;
         for (int i = 0; i < 8; i++) block[sha_pkg::LengthPos+i] = bits[63-8*i -: 8];
         fold_block();
         for (int i = 0; i < 8; i++)
            digest_q.push_back('{chain[i], 3'(i), i == 7});
         chain = InitHash;
         fill = 0;
         byte_total = '0;
      end
   endtask

   digest_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         chain = InitHash;
         fill = 0;
         byte_total = '0;
         digest_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $display("%0t unexpected digest word: got %h idx %0d last %b", $time,
                        rsp_digest_word, rsp_word_index, rsp_last_word);
               fail_count <= fail_count + 1;
            end else begin
               want = digest_q.pop_front();
               if (want.word !== rsp_digest_word || want.index !== rsp_word_index ||
                   want.last !== rsp_last_word) begin
                  $display("%0t digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                           $time, want.word, want.index, want.last,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) take_request(req_opcode, req_data_byte);
      end
      words_pending <= digest_q.size();
   end
endmodule

// ===== bench/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives messages of assorted lengths, padding boundaries included, through
// the hasher with random gaps and digest stalls; the checker scores digests.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
   localparam int IdleLimit = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count;
   int          words_pending;
   int          idle_cycles;
   bit          quiet;

   sha256_stream_hasher dut (.*);

   sha256_digest_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(9) < 6 || quiet) return 0;
      if ($urandom_range(9) < 8) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic send_request(input sha_pkg::opcode_type op, input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_message(input int len, input int fill_mode);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (fill_mode)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom);
         endcase
         send_request(sha_pkg::OP_ABSORB, b);
      end
      send_request(sha_pkg::OP_FINISH, 8'($urandom));
   endtask

   initial begin
      int len;
      req_valid     <= 1'b0;
      req_opcode    <= sha_pkg::OP_ABSORB;
      req_data_byte <= 8'h00;
      reset         <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: empty, short, a full block then 0x80 past the length field
      quiet = 1'b1;
      send_message(0, 2);
      send_message(3, 2);
      quiet = 1'b0;
      send_message(120, 2);
      send_request(sha_pkg::OP_FINISH, 8'hff);
      // random short messages
      for (int m = 0; m < 4; m++) begin
         quiet = (m % 4 == 3);
         len = $urandom_range(12);
         send_message(len, 2);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if ($urandom_range(19) == 0) begin
         rsp_ready <= 1'b0;
      end else if ($urandom_range(9) < 7 || quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end
endmodule
